>>> rtl/swid_pkg.sv
// ----------------------------------------------------------------------------
// swid_pkg: shared types and constants of the indexed-delete stack
// Word formats, command and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package swid_pkg;

    localparam int DEPTH  = 128;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_DELETE = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        t_command           command;
        logic signed [31:0] push_value;
        logic [6:0]         position;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] top_value;
        logic [7:0]         entry_count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_EXEC   = 3'd1,
        S_PEEK   = 3'd2,
        S_SHIFT  = 3'd3,
        S_RESULT = 3'd4
    } t_state;

    typedef struct packed {
        logic    load_item;
        logic    push_write;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    shift_start;
        logic    shift_step;
        logic    set_status;
        t_status status;
        logic    top_load;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_command command;
        logic     full;
        logic     empty;
        logic     bad_index;
        logic     del_top;
        logic     shift_last;
    } t_dp_stat;

endpackage

>>> rtl/stack_with_indexed_delete.sv
// ----------------------------------------------------------------------------
// stack_with_indexed_delete: bounded LIFO stack with delete at index
// Push, pop, peek and delete-at-index on a stack of signed 32-bit entries.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+-----------
//   in      | input     | i_in_valid / o_in_stall   | t_in_word
//   out     | output    | o_out_valid / i_out_stall | t_out_word
//
// Push and pop pass through the execute and result states; peek adds one read
// of the entry RAM. Delete of a valid index adds count - position - 1 shift
// steps, one entry moved per cycle through the RAM's read and write ports.
// One command is in work at a time.
// Reset empties the stack; entries are not cleared. A stalled result holds
// the next command in its final cycle until the output register frees.
// ----------------------------------------------------------------------------
module stack_with_indexed_delete import swid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    swid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    swid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_out_word (o_out_word)
    );

endmodule

>>> rtl/swid_ram.sv
// ----------------------------------------------------------------------------
// swid_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/swid_dp.sv
// ----------------------------------------------------------------------------
// swid_dp: stack datapath
// Entry store, entry count, shift pointer and result register; decodes the
// conditions the controller branches on.
// ----------------------------------------------------------------------------
module swid_dp import swid_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_word o_out_word
);

    t_in_word            r_item,   n_item;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [ADDR_W-1:0]   r_ptr,    n_ptr;
    t_status             r_status, n_status;
    logic signed [31:0]  r_top,    n_top;
    t_out_word           r_out,    n_out;

    logic [ADDR_W-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [31:0]         pos_ext;
    logic [31:0]         cnt_ext;
    logic [31:0]         ptr_ext;

    assign pos_ext = 32'(r_item.position);
    assign cnt_ext = 32'(r_count);
    assign ptr_ext = 32'(r_ptr);

    assign o_stat.command    = r_item.command;
    assign o_stat.full       = (cnt_ext == 32'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.bad_index  = (pos_ext >= cnt_ext);
    assign o_stat.del_top    = ((pos_ext + 32'd1) == cnt_ext);
    assign o_stat.shift_last = ((ptr_ext + 32'd2) == cnt_ext);

    always_comb begin
        if (i_cmd.shift_start) begin
            ram_raddr = ADDR_W'(pos_ext + 32'd1);
        end else if (i_cmd.shift_step) begin
            ram_raddr = ADDR_W'(ptr_ext + 32'd2);
        end else begin
            ram_raddr = ADDR_W'(cnt_ext - 32'd1);
        end
    end

    assign ram_we    = i_cmd.push_write | i_cmd.shift_step;
    assign ram_waddr = i_cmd.push_write ? ADDR_W'(cnt_ext) : r_ptr;
    assign ram_wdata = i_cmd.push_write ? DATA_W'(r_item.push_value) : ram_rdata;

    swid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_item   = r_item;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_status = r_status;
        n_top    = r_top;
        n_out    = r_out;
        if (i_cmd.load_item) begin
            n_item = i_in_word;
            n_top  = '0;
        end
        if (i_cmd.cnt_inc) begin
            n_count = CNT_W'(cnt_ext + 32'd1);
        end else if (i_cmd.cnt_dec) begin
            n_count = CNT_W'(cnt_ext - 32'd1);
        end
        if (i_cmd.shift_start) begin
            n_ptr = ADDR_W'(pos_ext);
        end else if (i_cmd.shift_step) begin
            n_ptr = ADDR_W'(ptr_ext + 32'd1);
        end
        if (i_cmd.set_status) begin
            n_status = i_cmd.status;
        end
        if (i_cmd.top_load) begin
            n_top = $signed(ram_rdata);
        end
        if (i_cmd.out_load) begin
            n_out.status      = r_status;
            n_out.top_value   = r_top;
            n_out.entry_count = cnt_ext[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_item   <= n_item;
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_top    <= n_top;
        r_out    <= n_out;
    end

    assign o_out_word = r_out;

endmodule

>>> rtl/swid_ctrl.sv
// ----------------------------------------------------------------------------
// swid_ctrl: stack controller
// Sequences one command at a time: execute, optional read wait or shift
// loop, then hand the result to the output register.
// ----------------------------------------------------------------------------
module swid_ctrl import swid_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_RESULT;
                unique case (i_stat.command)
                    CMD_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.push_write = 1'b1;
                            o_cmd.cnt_inc    = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    CMD_PEEK: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            n_state = S_PEEK;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.bad_index) begin
                            o_cmd.status = ST_BAD_INDEX;
                        end else if (i_stat.del_top) begin
                            o_cmd.cnt_dec = 1'b1;
                        end else begin
                            o_cmd.shift_start = 1'b1;
                            n_state           = S_SHIFT;
                        end
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_PEEK: begin
                o_cmd.top_load = 1'b1;
                n_state        = S_RESULT;
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/swid_chk.sv
// ----------------------------------------------------------------------------
// swid_chk: port checker for the indexed-delete stack
// Watches the top level's ports and flags results that break the stack's
// rules; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module swid_chk import swid_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted a word while another was in work");

    a_top_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.top_value != 32'sd0))
            |-> (o_out_word.status == ST_OK))
        else $error("nonzero top value on a failed command");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_FULL))
            |-> (32'(o_out_word.entry_count) == (DEPTH % 256)))
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_EMPTY))
            |-> (o_out_word.entry_count == 8'd0))
        else $error("empty reported with entries held");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

endmodule

bind stack_with_indexed_delete swid_chk u_swid_chk (.*);

>>> verif/stack_with_indexed_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_indexed_delete_tb: self-checking bench for the indexed-delete stack
// Drives push, pop, peek and delete-at-index command words with random gaps
// and output stalls, and predicts every result word from its own copy of
// the stack. Covers the empty and full stack, out-of-range deletes, the
// longest shift, long output hold-off and a long random walk over fill levels.
// ----------------------------------------------------------------------------
module stack_with_indexed_delete_tb;
    import swid_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int WALK_ITEMS   = 1650;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    logic signed [31:0] model_entries [DEPTH];
    int                 model_count = 0;
    t_out_word          pending_results [$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    bit                 idle_enable = 1'b1;
    bit                 hold_request = 1'b0;
    int unsigned        stall_left = 0;

    stack_with_indexed_delete DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(9) == 0) begin
            return $urandom_range(60, 15);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word make_word(input t_command cmd, input logic signed [31:0] value,
                                           input logic [6:0] pos);
        t_in_word w;
        w.command    = cmd;
        w.push_value = value;
        w.position   = pos;
        return w;
    endfunction

    function automatic t_out_word apply_stack_command(input t_in_word w);
        t_out_word r;
        r.status    = ST_OK;
        r.top_value = '0;
        case (w.command)
            CMD_PUSH: begin
                if (model_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_entries[model_count] = w.push_value;
                    model_count++;
                end
            end
            CMD_POP: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_count--;
                end
            end
            CMD_PEEK: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.top_value = model_entries[model_count - 1];
                end
            end
            default: begin
                if (int'(w.position) >= model_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (int k = int'(w.position); k + 1 < model_count; k++) begin
                        model_entries[k] = model_entries[k + 1];
                    end
                    model_count--;
                end
            end
        endcase
        r.entry_count = 8'(model_count);
        return r;
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(apply_stack_command(w));
        if (idle_enable && $urandom_range(1) == 0) begin
            gap = pick_gap();
            i_in_valid <= 1'b0;
            i_in_word  <= make_word(t_command'($urandom_range(3)), $urandom, 7'($urandom));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Output stall: random bursts, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_enable && $urandom_range(3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no command waiting: status %0d count %0d",
                       o_out_word.status, o_out_word.entry_count);
                error_count++;
            end else begin
                exp_word = pending_results.pop_front();
                if (o_out_word.status !== exp_word.status) begin
                    $error("status: expected %s, actual %0d", exp_word.status.name(),
                           o_out_word.status);
                    error_count++;
                end
                if (o_out_word.top_value !== exp_word.top_value) begin
                    $error("top_value: expected %0d, actual %0d", exp_word.top_value,
                           o_out_word.top_value);
                    error_count++;
                end
                if (o_out_word.entry_count !== exp_word.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d", exp_word.entry_count,
                           o_out_word.entry_count);
                    error_count++;
                end
            end
        end
    end

    task automatic test_empty_stack();
        send_word(make_word(CMD_PEEK, 32'sh5A5A_5A5A, 7'd0));
        send_word(make_word(CMD_POP, 32'sh0000_0001, 7'd127));
        send_word(make_word(CMD_DELETE, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_DELETE, 32'shFFFF_FFFF, 7'd127));
    endtask

    task automatic test_basic_ops();
        send_word(make_word(CMD_PUSH, 32'sh7FFF_FFFF, 7'd127));
        send_word(make_word(CMD_PUSH, 32'sh8000_0000, 7'd0));
        send_word(make_word(CMD_PUSH, 32'sh0000_0000, 7'd85));
        send_word(make_word(CMD_PUSH, 32'shFFFF_FFFF, 7'd42));
        send_word(make_word(CMD_PEEK, 32'sh1357_9BDF, 7'd3));
        send_word(make_word(CMD_DELETE, 32'sh0000_0000, 7'd4));
        send_word(make_word(CMD_DELETE, 32'sh0000_0000, 7'd3));
        send_word(make_word(CMD_PEEK, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_DELETE, 32'sh2468_ACE0, 7'd0));
        send_word(make_word(CMD_PEEK, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_POP, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_PEEK, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_POP, 32'sh0000_0000, 7'd0));
        send_word(make_word(CMD_POP, 32'sh0000_0000, 7'd0));
    endtask

    task automatic test_fill_to_capacity();
        while (model_count < DEPTH) begin
            send_word(make_word(CMD_PUSH, pick_value(), 7'($urandom)));
        end
        send_word(make_word(CMD_PUSH, pick_value(), 7'd0));
        send_word(make_word(CMD_PEEK, pick_value(), 7'd0));
        send_word(make_word(CMD_DELETE, pick_value(), 7'd127));
        send_word(make_word(CMD_PUSH, pick_value(), 7'd0));
        send_word(make_word(CMD_DELETE, pick_value(), 7'd0));
        send_word(make_word(CMD_PEEK, pick_value(), 7'd0));
        send_word(make_word(CMD_DELETE, pick_value(), 7'd127));
        while (model_count > 0) begin
            send_word(make_word($urandom_range(3) == 0 ? CMD_DELETE : CMD_POP, pick_value(),
                                7'($urandom_range(model_count - 1))));
        end
        send_word(make_word(CMD_POP, pick_value(), 7'd0));
    endtask

    task automatic test_output_hold_off();
        wait_drained();
        idle_enable  = 1'b0;
        hold_request = 1'b1;
        repeat (12) begin
            send_word(make_word(t_command'($urandom_range(3)), pick_value(),
                                7'($urandom_range(model_count))));
        end
        wait_drained();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_walk(input int n_items);
        int       target_level;
        int       roll;
        t_command cmd;
        logic [6:0] pos;
        target_level = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) begin
                roll = $urandom_range(9);
                if (roll < 4) begin
                    target_level = $urandom_range(8);
                end else if (roll < 8) begin
                    target_level = $urandom_range(100, 9);
                end else begin
                    target_level = $urandom_range(DEPTH, DEPTH - 6);
                end
                idle_enable = ($urandom_range(4) != 0);
            end
            roll = $urandom_range(99);
            if (roll < 5) begin
                cmd = t_command'($urandom_range(3));
            end else if (roll < 15) begin
                cmd = CMD_PEEK;
            end else if (model_count < target_level) begin
                cmd = (roll < 75) ? CMD_PUSH : ((roll < 88) ? CMD_POP : CMD_DELETE);
            end else if (model_count > target_level) begin
                cmd = (roll < 50) ? CMD_POP : ((roll < 85) ? CMD_DELETE : CMD_PUSH);
            end else begin
                cmd = t_command'($urandom_range(3));
            end
            if (model_count == 0 || $urandom_range(9) == 0) begin
                pos = 7'($urandom);
            end else if ($urandom_range(4) == 0) begin
                pos = 7'(model_count - 1);
            end else begin
                pos = 7'($urandom_range(model_count - 1));
            end
            send_word(make_word(cmd, pick_value(), pos));
        end
        // hold the sender until the stack has answered everything
        wait_drained();
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_stack();
        test_basic_ops();
        test_fill_to_capacity();
        test_output_hold_off();
        test_random_walk(WALK_ITEMS);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/swid_pkg.sv
rtl/swid_ram.sv
rtl/swid_dp.sv
rtl/swid_ctrl.sv
rtl/stack_with_indexed_delete.sv
rtl/swid_chk.sv
verif/stack_with_indexed_delete_tb.sv
